// ----- design/pip_pkg.sv -----
// ----------------------------------------------------------------------------
// pip_pkg
// shared constants, types and command codes for the point-in-polygon block
// ----------------------------------------------------------------------------
package pip_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int COORD_BITS   = 10;
  localparam int ADDR_BITS    = $clog2(MAX_VERTICES);
  localparam int CNT_BITS     = $clog2(MAX_VERTICES + 1);
  localparam int OUT_CNT_BITS = 7;
  localparam int VTX_BITS     = 2 * COORD_BITS;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  typedef logic [COORD_BITS-1:0]   coord_t;
  typedef logic [ADDR_BITS-1:0]    addr_t;
  typedef logic [CNT_BITS-1:0]     cnt_t;
  typedef logic [OUT_CNT_BITS-1:0] xcount_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } vertex_t;

  typedef struct packed {
    logic [1:0] opcode;
    coord_t     coord_x;
    coord_t     coord_y;
  } in_t;

  typedef struct packed {
    logic    inside_res;
    xcount_t crossing_count;
    logic    status;
  } out_t;

endpackage

// ----- design/pip_ram.sv -----
// ----------------------------------------------------------------------------
// pip_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module pip_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/pip_edge_unit.sv -----
// ----------------------------------------------------------------------------
// pip_edge_unit
// shared edge test: cross-multiplied crossing check, products registered
// ----------------------------------------------------------------------------
module pip_edge_unit (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  input  pip_pkg::vertex_t point,
  input  pip_pkg::vertex_t va,
  input  pip_pkg::vertex_t vb,
  output logic             hit_valid,
  output logic             hit
);

  localparam int DW = pip_pkg::COORD_BITS + 1;
  localparam int PW = 2 * DW;

  logic signed [DW-1:0] dy;
  logic signed [DW-1:0] dx;
  logic signed [DW-1:0] dpy;
  logic signed [DW-1:0] dpx;
  logic signed [PW-1:0] lhs_next;
  logic signed [PW-1:0] rhs_next;
  logic                 in_span;
  logic signed [PW-1:0] lhs;
  logic signed [PW-1:0] rhs;
  logic                 dy_pos;
  logic                 span_ok;

  always_comb begin
    dy  = $signed({1'b0, vb.y}) - $signed({1'b0, va.y});
    dx  = $signed({1'b0, vb.x}) - $signed({1'b0, va.x});
    dpy = $signed({1'b0, point.y}) - $signed({1'b0, va.y});
    dpx = $signed({1'b0, point.x}) - $signed({1'b0, va.x});
    lhs_next = dpy * dx;
    rhs_next = dpx * dy;
    // lower end inclusive, upper end exclusive; horizontal edges never pass
    if (va.y < vb.y) begin
      in_span = (point.y >= va.y) && (point.y < vb.y);
    end else if (vb.y < va.y) begin
      in_span = (point.y >= vb.y) && (point.y < va.y);
    end else begin
      in_span = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_valid <= 1'b0;
    end else begin
      hit_valid <= req_valid;
    end
    lhs     <= lhs_next;
    rhs     <= rhs_next;
    dy_pos  <= !dy[DW-1];
    span_ok <= in_span;
  end

  assign hit = span_ok && (dy_pos ? (lhs > rhs) : (lhs < rhs));

endmodule

// ----- design/point_in_polygon_test_top.sv -----
// ----------------------------------------------------------------------------
// point_in_polygon_test_top
// polygon vertex store with ray-crossing parity point queries
// ----------------------------------------------------------------------------
// clear, append, unused opcode and query on an empty polygon: the sequencer goes
//   straight from idle to done, then the result is registered into the output register
// query on n >= 1 stored vertices: the sequencer passes through read, drain and done,
//   one edge per cycle through the single edge unit fed by the one ram read port
// one command in flight at a time; next command accepted when the sequencer is
//   idle, even while the previous result still waits in the output register
// synchronous active-high reset empties the polygon; ram contents are not cleared
module point_in_polygon_test_top (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  pip_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output pip_pkg::out_t  out_data
);

  // sequencer states
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_READ  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]        state;
  logic [1:0]        state_next;
  pip_pkg::cnt_t     vcount;         // stored vertex count
  pip_pkg::cnt_t     rd_cnt;         // read issue counter, issues reads 0..n
  pip_pkg::cnt_t     xcnt;           // crossing accumulator
  pip_pkg::vertex_t  qpt;            // query point
  pip_pkg::vertex_t  prev_v;         // previous vertex off the ram
  pip_pkg::out_t     res;            // result waiting for the output register
  logic              rv;             // ram read data valid this cycle
  logic              rfirst;         // read data is the first vertex of the walk

  logic              accept;
  logic              full;
  logic              ram_we;
  pip_pkg::addr_t    raddr;
  logic [pip_pkg::VTX_BITS-1:0] rdata;
  pip_pkg::vertex_t  rvtx;
  logic              edge_req;
  logic              hit_valid;
  logic              hit;
  logic              out_free;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign full     = (vcount == pip_pkg::cnt_t'(pip_pkg::MAX_VERTICES));
  assign ram_we   = accept && (in_data.opcode == pip_pkg::OP_APPEND) && !full;
  assign out_free = !out_valid || out_ready;

  // last read wraps back to vertex 0 to form the closing edge
  assign raddr = (rd_cnt == vcount) ? '0 : rd_cnt[pip_pkg::ADDR_BITS-1:0];

  pip_ram #(
    .WIDTH (pip_pkg::VTX_BITS),
    .DEPTH (pip_pkg::MAX_VERTICES)
  ) u_vram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (vcount[pip_pkg::ADDR_BITS-1:0]),
    .wdata ({in_data.coord_x, in_data.coord_y}),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rvtx     = pip_pkg::vertex_t'(rdata);
  // an edge is ready once two consecutive vertices have come out of the ram
  assign edge_req = rv && !rfirst;

  pip_edge_unit u_edge (
    .clk       (clk),
    .rst       (rst),
    .req_valid (edge_req),
    .point     (qpt),
    .va        (prev_v),
    .vb        (rvtx),
    .hit_valid (hit_valid),
    .hit       (hit)
  );

  // next-state logic
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (in_data.opcode == pip_pkg::OP_QUERY && vcount != '0) begin
            state_next = S_READ;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_READ: begin
        if (rd_cnt == vcount) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // pipeline empty once no read data and no edge result in flight
        if (!rv && !hit_valid) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      vcount    <= '0;
      rv        <= 1'b0;
      rfirst    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      rv     <= (state == S_READ);
      rfirst <= (state == S_READ) && (rd_cnt == '0);
      if (accept && in_data.opcode == pip_pkg::OP_CLEAR) begin
        vcount <= '0;
      end else if (ram_we) begin
        vcount <= vcount + pip_pkg::cnt_t'(1);
      end
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      qpt    <= pip_pkg::vertex_t'({in_data.coord_x, in_data.coord_y});
      rd_cnt <= '0;
      xcnt   <= '0;
      // only a dropped append reports a nonzero status
      res    <= pip_pkg::out_t'({1'b0, pip_pkg::xcount_t'(0),
                                 (in_data.opcode == pip_pkg::OP_APPEND) && full});
    end else begin
      if (state == S_READ) begin
        rd_cnt <= rd_cnt + pip_pkg::cnt_t'(1);
      end
      if (hit_valid && hit) begin
        xcnt <= xcnt + pip_pkg::cnt_t'(1);
      end
      if (state == S_DRAIN && !rv && !hit_valid) begin
        res <= pip_pkg::out_t'({xcnt[0], pip_pkg::xcount_t'(xcnt), 1'b0});
      end
    end
    if (rv) begin
      prev_v <= rvtx;
    end
    if (state == S_DONE && out_free) begin
      out_data <= res;
    end
  end

endmodule
